>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication every clock, idle during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check an implication whose consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/core/knn_pkg.sv
// Types and constants of the k-nearest-neighbor search block.
// No dependencies.
`timescale 1ns / 1ps
package knn_pkg;
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIM   = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef struct packed {
      logic               action;
      logic signed [15:0] value;
      logic               last;
      logic [63:0]        id;
      logic [4:0]         k;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] id_res;
      logic [3:0]  rank;
      logic        last_res;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic take;       // write accepted component
      logic scan_start; // clear accumulator, start at entry 0 comp 0
      logic scan_step;  // read next component pair
      logic emit_load;  // load emit rank 0
      logic emit_step;  // advance emit rank
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_done;
      logic emit_done;
      logic dist_ready;
      logic insert_full;
   } sts_type;
endpackage

>>> rtl/core/knn_brute_force_search_top.sv
// Top level of the brute-force k-nearest-neighbor search block.
// Depends on knn_pkg, knn_ctrl, knn_datapath and assert_macros.svh.
//
// Usage: stream insert or query components on req_ (valid/stall), one per
// cycle unless stalled. The last insert component commits the vector with
// its id and returns one status result on rsp_. The last query component
// starts a scan of every stored entry, one component per cycle from the
// component memory read port, after which the k nearest ids leave nearest
// first (id memory read then output register). A dimension mismatch or a
// full or empty store gives an error status. Non-last components give no
// result. csr_ writes the dimension (reset value 64) while idle; the user
// must ensure this, the block does not. Reset empties the store and clears
// the component counter; memories keep their contents. When rsp_stall is
// high the result register holds and req_stall rises until it drains.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module knn_brute_force_search_top #(
   parameter int CAPACITY = 1024,
   parameter int DIM_MAX  = 64,
   parameter int MAX_K    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  knn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output knn_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [6:0]       csr_dimension
);
   import knn_pkg::*;

   localparam int EW = $clog2(CAPACITY+1);
   localparam int CW = $clog2(DIM_MAX+1);
   localparam int KW = $clog2(MAX_K+1);

   // configuration register
   logic [6:0] dim_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) dim_ff <= 7'd64;
      else if (csr_valid) dim_ff <= csr_dimension;
   end

   cmd_type cmd;
   sts_type sts;
   logic commit_insert, overflow, emit_last, mismatch;
   logic [EW-1:0] entry_count;
   logic [CW-1:0] comp_count, cnt_after;
   logic [63:0] emit_id;
   logic [KW-1:0] emit_rank;

   // count including the item now taken
   assign cnt_after = (comp_count < CW'(DIM_MAX)) ? comp_count + 1'b1 : comp_count;
   assign mismatch = overflow || (comp_count >= CW'(DIM_MAX))
                     || (32'(cnt_after) != 32'(dim_ff));

   knn_datapath #(.CAPACITY(CAPACITY), .DIM_MAX(DIM_MAX), .MAX_K(MAX_K)) u_dp (
      .clock, .reset, .req(req_data), .cmd, .dimension(dim_ff), .commit_insert,
      .entry_count, .comp_count, .overflow, .sts, .emit_id, .emit_rank, .emit_last
   );

   knn_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req(req_data), .rsp_stall,
      .rsp_valid, .rsp(rsp_data), .mismatch, .empty(entry_count == '0), .sts,
      .emit_id, .emit_rank(4'(emit_rank)), .emit_last, .cmd, .commit_insert
   );

   `ASSERT_IMPL(a_no_overfill, clock, reset, commit_insert, entry_count < EW'(CAPACITY))
   `ASSERT_NEXT(a_commit_grows, clock, reset, commit_insert,
                entry_count == $past(entry_count) + 1'b1)
endmodule

>>> rtl/core/knn_datapath.sv
// Datapath: vector stores, distance accumulator, sorted best list.
// Depends on knn_pkg.
`timescale 1ns / 1ps
module knn_datapath #(
   parameter int CAPACITY = 1024,
   parameter int DIM_MAX  = 64,
   parameter int MAX_K    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  knn_pkg::req_type  req,
   input  knn_pkg::cmd_type  cmd,
   input  logic [6:0]        dimension,
   input  logic              commit_insert,
   output logic [$clog2(CAPACITY+1)-1:0] entry_count,
   output logic [$clog2(DIM_MAX+1)-1:0]  comp_count,
   output logic              overflow,
   output knn_pkg::sts_type  sts,
   output logic [63:0]       emit_id,
   output logic [$clog2(MAX_K+1)-1:0] emit_rank,
   output logic              emit_last
);
   import knn_pkg::*;

   localparam int EW = $clog2(CAPACITY+1);
   localparam int EI = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(DIM_MAX+1);
   localparam int CI = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
   localparam int KW = $clog2(MAX_K+1);
   localparam int KI = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int DW = 34 + CW;
   localparam int AW = EI + CI;

   // memories
   logic signed [15:0] comp_mem [CAPACITY*DIM_MAX];
   logic [63:0]        id_mem   [CAPACITY];
   logic signed [15:0] query_mem [DIM_MAX];

   logic [EW-1:0] entry_ff, entry_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;

   assign entry_count = entry_ff;
   assign comp_count  = cnt_ff;
   assign overflow    = ovf_ff;
   assign sts.insert_full = (entry_ff >= EW'(CAPACITY));

   // component counter and entry count
   always_comb begin
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      entry_in = entry_ff;
      if (cmd.take) begin
         if (cnt_ff < CW'(DIM_MAX)) cnt_in = cnt_ff + 1'b1;
         else ovf_in = 1'b1;
         if (req.last) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end
      end
      if (commit_insert) entry_in = entry_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         entry_ff <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         entry_ff <= entry_in;
      end
   end

   // write stores
   logic [AW-1:0] wr_addr;
   assign wr_addr = AW'(entry_ff[EI-1:0]) * AW'(DIM_MAX) + AW'(cnt_ff[CI-1:0]);
   always_ff @(posedge clock) begin
      if (cmd.take && cnt_ff < CW'(DIM_MAX)) begin
         if (req.action == ACT_INSERT) begin
            if (!sts.insert_full) comp_mem[wr_addr] <= req.value;
         end else begin
            query_mem[cnt_ff[CI-1:0]] <= req.value;
         end
      end
      if (commit_insert) id_mem[entry_ff[EI-1:0]] <= req.id;
   end

   // scan addressing: entry e, component c
   logic [EI-1:0] se_ff, se_in;
   logic [CI-1:0] sc_ff, sc_in;
   logic          scan_ff, scan_in;
   logic [AW-1:0] rd_base_ff, rd_base_in;
   logic [CI-1:0] dlast;
   assign dlast = CI'(dimension - 7'd1);

   always_comb begin
      se_in = se_ff; sc_in = sc_ff; scan_in = scan_ff; rd_base_in = rd_base_ff;
      if (cmd.scan_start) begin
         se_in = '0; sc_in = '0; scan_in = 1'b1; rd_base_in = '0;
      end else if (cmd.scan_step && scan_ff) begin
         if (sc_ff == dlast) begin
            sc_in = '0;
            rd_base_in = rd_base_ff + AW'(DIM_MAX);
            if (EW'(se_ff) == entry_ff - 1'b1) scan_in = 1'b0;
            else se_in = se_ff + 1'b1;
         end else begin
            sc_in = sc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) scan_ff <= 1'b0;
      else scan_ff <= scan_in;
      se_ff <= se_in; sc_ff <= sc_in; rd_base_ff <= rd_base_in;
   end

   // stage 1: registered reads
   logic signed [15:0] rs_ff, rq_ff;
   logic s1_v_ff, s1_end_ff;
   logic [EI-1:0] s1_e_ff;
   always_ff @(posedge clock) begin
      rs_ff <= comp_mem[rd_base_ff + AW'(sc_ff)];
      rq_ff <= query_mem[sc_ff];
      s1_e_ff <= se_ff;
      s1_end_ff <= (sc_ff == dlast);
   end
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else s1_v_ff <= cmd.scan_step && scan_ff;
   end

   // stage 2: difference squared
   logic signed [16:0] diff;
   logic [33:0] sq_ff;
   logic s2_v_ff, s2_end_ff;
   logic [EI-1:0] s2_e_ff;
   assign diff = 17'(rs_ff) - 17'(rq_ff);
   always_ff @(posedge clock) begin
      sq_ff <= 34'(diff * diff);
      s2_end_ff <= s1_end_ff;
      s2_e_ff <= s1_e_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else s2_v_ff <= s1_v_ff;
   end

   // stage 3: accumulate
   logic [DW-1:0] acc_ff;
   logic d_v_ff;
   logic [DW-1:0] dist_ff;
   logic [EI-1:0] d_e_ff;
   always_ff @(posedge clock) begin
      if (cmd.scan_start) acc_ff <= '0;
      else if (s2_v_ff) acc_ff <= s2_end_ff ? '0 : acc_ff + DW'(sq_ff);
      if (s2_v_ff && s2_end_ff) begin
         dist_ff <= acc_ff + DW'(sq_ff);
         d_e_ff  <= s2_e_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else d_v_ff <= s2_v_ff && s2_end_ff;
   end
   assign sts.dist_ready = d_v_ff;
   assign sts.scan_done = !scan_ff && !s1_v_ff && !s2_v_ff && !d_v_ff;

   // sorted insertion into best list, one candidate per cycle
   logic [DW-1:0] bd_ff [MAX_K];
   logic [EI-1:0] bi_ff [MAX_K];
   logic [KW-1:0] filled_ff, filled_in, want_ff, want_in;
   logic [4:0] kc;
   logic [31:0] kcap;
   always_comb begin
      kc = (req.k == 5'd0) ? 5'd1 : req.k;
      // clamp k to the list size, then to the stored count
      kcap = (32'(kc) > MAX_K) ? 32'(MAX_K) : 32'(kc);
      if (kcap > 32'(entry_ff)) kcap = 32'(entry_ff);
      want_in = KW'(kcap);
      filled_in = filled_ff;
      if (cmd.scan_start) filled_in = '0;
      else if (d_v_ff && filled_ff < want_ff) filled_in = filled_ff + 1'b1;
   end
   always_ff @(posedge clock) begin
      if (reset) filled_ff <= '0;
      else filled_ff <= filled_in;
      if (cmd.scan_start) want_ff <= want_in;
   end

   logic [MAX_K-1:0] gt;
   always_comb begin
      for (int r = 0; r < MAX_K; r++)
         gt[r] = (KW'(r) < filled_ff) && (dist_ff < bd_ff[r]);
   end
   always_ff @(posedge clock) begin
      if (d_v_ff) begin
         for (int r = 0; r < MAX_K; r++) begin
            if (KW'(r) < want_ff) begin
               if (gt[r] && (r == 0 || !gt[r > 0 ? r-1 : 0])) begin
                  bd_ff[r] <= dist_ff; bi_ff[r] <= d_e_ff;
               end else if (r > 0 && gt[r > 0 ? r-1 : 0]) begin
                  bd_ff[r] <= bd_ff[r > 0 ? r-1 : 0];
                  bi_ff[r] <= bi_ff[r > 0 ? r-1 : 0];
               end else if (!gt[r] && KW'(r) == filled_ff) begin
                  bd_ff[r] <= dist_ff; bi_ff[r] <= d_e_ff;
               end
            end
         end
      end
   end

   // emit: read id memory per rank
   logic [KW-1:0] er_ff;
   always_ff @(posedge clock) begin
      if (cmd.emit_load) er_ff <= '0;
      else if (cmd.emit_step) er_ff <= er_ff + 1'b1;
   end
   logic [KI-1:0] er_idx;
   assign er_idx = er_ff[KI-1:0];
   always_ff @(posedge clock) begin
      emit_id <= id_mem[bi_ff[er_idx]];
   end
   assign emit_rank = er_ff;
   assign emit_last = (er_ff + 1'b1 == filled_ff);
   assign sts.emit_done = emit_last;
endmodule

>>> rtl/core/knn_ctrl.sv
// Controller state machine for the k-nearest-neighbor search block.
// Depends on knn_pkg.
`timescale 1ns / 1ps
module knn_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  knn_pkg::req_type req,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output knn_pkg::rsp_type rsp,
   input  logic             mismatch,
   input  logic             empty,
   input  knn_pkg::sts_type sts,
   input  logic [63:0]      emit_id,
   input  logic [3:0]       emit_rank,
   input  logic             emit_last,
   output knn_pkg::cmd_type cmd,
   output logic             commit_insert
);
   import knn_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;
   localparam logic [2:0] S_HOLD = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       vld_ff, vld_in;
   rsp_type    rsp_ff, rsp_in;
   logic       take;

   assign req_stall = (state_ff != S_IDLE) || (vld_ff && rsp_stall);
   assign take = req_valid && !req_stall;
   assign rsp_valid = vld_ff;
   assign rsp = rsp_ff;

   always_comb begin
      state_in = state_ff;
      vld_in = vld_ff && rsp_stall;
      rsp_in = rsp_ff;
      cmd = '0;
      commit_insert = 1'b0;
      cmd.take = take;
      case (state_ff)
         S_IDLE: begin
            if (take && req.last) begin
               vld_in = 1'b1;
               rsp_in = '{status: ST_OK, id_res: 64'd0, rank: 4'd0, last_res: 1'b1};
               if (mismatch) rsp_in.status = ST_DIM;
               else if (req.action == ACT_INSERT) begin
                  if (sts.insert_full) rsp_in.status = ST_FULL;
                  else commit_insert = 1'b1;
               end else if (empty) rsp_in.status = ST_EMPTY;
               else begin
                  vld_in = 1'b0;
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.emit_load = 1'b1;
            state_in = S_READ;
         end
         S_READ: state_in = S_EMIT;
         S_EMIT: begin
            if (!vld_ff || !rsp_stall) begin
               vld_in = 1'b1;
               rsp_in = '{status: ST_OK, id_res: emit_id, rank: emit_rank,
                          last_res: emit_last};
               if (emit_last) state_in = S_IDLE;
               else begin
                  cmd.emit_step = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      rsp_ff <= rsp_in;
   end
endmodule
